FILE: rtl/dmx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_pkg
// Shared types and constants for the multichannel to stereo downmix.
// ----------------------------------------------------------------------------
package dmx_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned NumSlots  = 9;
  localparam int unsigned SlotIdxW  = 4;
  localparam int unsigned GainW     = 13;
  localparam int unsigned PreW      = 18;  // sum of three samples
  localparam int unsigned ProdW     = 32;  // mid sum times gain
  localparam int unsigned FullW     = 33;  // full-width fold before the shift
  localparam int unsigned ContribShift = 12;
  localparam int unsigned OutShift  = 13;
  localparam int unsigned ShiftW    = FullW - OutShift;
  localparam int unsigned AccW      = ShiftW + 1;

  localparam logic [GainW-1:0] GainReset = 13'd2896;

  localparam logic signed [AccW-1:0] SampleMax = 21'sd32767;
  localparam logic signed [AccW-1:0] SampleMin = -21'sd32768;

  typedef enum logic [2:0] {
    CFG_HAS_CENTER      = 3'd0,
    CFG_HAS_LFE         = 3'd1,
    CFG_HAS_BACK_PAIR   = 3'd2,
    CFG_HAS_BACK_CENTER = 3'd3,
    CFG_HAS_SIDE_PAIR   = 3'd4,
    CFG_ACCUMULATE_MODE = 3'd5,
    CFG_CENTER_GAIN     = 3'd6
  } dmx_cfg_idx_e;

  // channel presence flags
  typedef struct packed {
    logic has_center;
    logic has_lfe;
    logic has_back_pair;
    logic has_back_center;
    logic has_side_pair;
  } dmx_layout_t;

  // per-side partial sums and the shared mid sum
  typedef struct packed {
    logic signed [PreW-1:0] lt_pre;
    logic signed [PreW-1:0] rt_pre;
    logic signed [PreW-1:0] mid;
  } dmx_sel_t;

endpackage

FILE: rtl/dmx_slot_sel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_slot_sel
// Maps the packed frame slots to channels and forms the left, right and
// mid partial sums.
// ----------------------------------------------------------------------------
module dmx_slot_sel
  import dmx_pkg::*;
(
  input  dmx_layout_t                layout_i,
  input  logic signed [SampleW-1:0]  slot_i [NumSlots],
  output dmx_sel_t                   sel_o
);

  logic [SlotIdxW-1:0] pos_fc, pos_lfe, pos_bl, pos_br, pos_bc, pos_sl, pos_sr;
  logic signed [PreW-1:0] fc, lfe, bc, bl, br, sl, sr;

  // slot positions follow the channel order FL FR FC LFE BL BR BC SL SR
  always_comb begin
    pos_fc  = layout_i.has_center      ? 4'd2          : 4'd1;
    pos_lfe = layout_i.has_lfe         ? pos_fc + 4'd1 : pos_fc;
    pos_bl  = layout_i.has_back_pair   ? pos_lfe + 4'd1 : pos_lfe;
    pos_br  = layout_i.has_back_pair   ? pos_bl + 4'd1 : pos_bl;
    pos_bc  = layout_i.has_back_center ? pos_br + 4'd1 : pos_br;
    pos_sl  = layout_i.has_side_pair   ? pos_bc + 4'd1 : pos_bc;
    pos_sr  = layout_i.has_side_pair   ? pos_sl + 4'd1 : pos_sl;
  end

  always_comb begin
    fc  = layout_i.has_center      ? PreW'(slot_i[pos_fc])  : '0;
    lfe = layout_i.has_lfe         ? PreW'(slot_i[pos_lfe]) : '0;
    bc  = layout_i.has_back_center ? PreW'(slot_i[pos_bc])  : '0;
    bl  = layout_i.has_back_pair   ? PreW'(slot_i[pos_bl])  : '0;
    br  = layout_i.has_back_pair   ? PreW'(slot_i[pos_br])  : '0;
    sl  = layout_i.has_side_pair   ? PreW'(slot_i[pos_sl])  : '0;
    sr  = layout_i.has_side_pair   ? PreW'(slot_i[pos_sr])  : '0;

    sel_o.lt_pre = PreW'(slot_i[0]) + sl + bl;
    sel_o.rt_pre = PreW'(slot_i[1]) + sr + br;
    sel_o.mid    = fc + lfe + bc;
  end

endmodule

FILE: rtl/dmx_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_lane
// One output side: adds the scaled mid term, shifts down, optionally adds
// the previous output sample and saturates to 16 bits.
// ----------------------------------------------------------------------------
module dmx_lane
  import dmx_pkg::*;
(
  input  logic signed [PreW-1:0]    pre_i,
  input  logic signed [ProdW-1:0]   prod_i,
  input  logic signed [SampleW-1:0] prev_i,
  input  logic                      acc_i,
  output logic signed [SampleW-1:0] sample_o
);

  logic signed [FullW-1:0]  full;
  logic signed [ShiftW-1:0] shifted;
  logic signed [AccW-1:0]   acc_sum;

  always_comb begin
    full    = (FullW'(pre_i) <<< ContribShift) + FullW'(prod_i);
    // dropping the low bits of a two's complement value floors it
    shifted = full[FullW-1:OutShift];
    acc_sum = AccW'(shifted) + (acc_i ? AccW'(prev_i) : '0);
    if (acc_sum > SampleMax) begin
      sample_o = SampleMax[SampleW-1:0];
    end else if (acc_sum < SampleMin) begin
      sample_o = SampleMin[SampleW-1:0];
    end else begin
      sample_o = acc_sum[SampleW-1:0];
    end
  end

endmodule

FILE: rtl/multichannel_stereo_downmix_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_stereo_downmix_top
// Folds one packed multichannel frame per word to a saturated stereo pair.
// ----------------------------------------------------------------------------
// Takes one frame per clock while the output is not stalled and gives one
// stereo word per frame, in order. A frame passes through a slot select
// and partial sum stage, a gain multiply stage, and the left/right fold lanes
// feeding the output register. Each stage holds its word under output
// back-pressure, so up to three frames are in flight and in_ready_o drops
// only when all stages are full and the output is stalled. Configuration
// must be written through cfg_we_i/cfg_idx_i/cfg_wdata_i only while no frame
// is in flight; the block itself does not enforce this.
module multichannel_stereo_downmix_top
  import dmx_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,

  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [GainW-1:0]          cfg_wdata_i,

  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] slot0_i,
  input  logic signed [SampleW-1:0] slot1_i,
  input  logic signed [SampleW-1:0] slot2_i,
  input  logic signed [SampleW-1:0] slot3_i,
  input  logic signed [SampleW-1:0] slot4_i,
  input  logic signed [SampleW-1:0] slot5_i,
  input  logic signed [SampleW-1:0] slot6_i,
  input  logic signed [SampleW-1:0] slot7_i,
  input  logic signed [SampleW-1:0] slot8_i,
  input  logic signed [SampleW-1:0] prev_left_i,
  input  logic signed [SampleW-1:0] prev_right_i,
  input  logic                      last_frame_i,

  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] left_out_o,
  output logic signed [SampleW-1:0] right_out_o,
  output logic                      last_out_o
);

  // configuration registers
  dmx_layout_t      layout_q;
  logic             acc_mode_q;
  logic [GainW-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q   <= '0;
      acc_mode_q <= 1'b0;
      gain_q     <= GainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HAS_CENTER:      layout_q.has_center      <= cfg_wdata_i[0];
        CFG_HAS_LFE:         layout_q.has_lfe         <= cfg_wdata_i[0];
        CFG_HAS_BACK_PAIR:   layout_q.has_back_pair   <= cfg_wdata_i[0];
        CFG_HAS_BACK_CENTER: layout_q.has_back_center <= cfg_wdata_i[0];
        CFG_HAS_SIDE_PAIR:   layout_q.has_side_pair   <= cfg_wdata_i[0];
        CFG_ACCUMULATE_MODE: acc_mode_q               <= cfg_wdata_i[0];
        CFG_CENTER_GAIN:     gain_q                   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage advance chain, each stage moves when its successor can take it
  logic sel_valid_q, mul_valid_q, out_valid_q;
  logic sel_en, mul_en, out_en;

  assign out_en     = !out_valid_q || out_ready_i;
  assign mul_en     = !mul_valid_q || out_en;
  assign sel_en     = !sel_valid_q || mul_en;
  assign in_ready_o = sel_en;

  // stage 1: slot select and partial sums
  logic signed [SampleW-1:0] slots [NumSlots];
  dmx_sel_t sel_d, sel_q;

  assign slots[0] = slot0_i;
  assign slots[1] = slot1_i;
  assign slots[2] = slot2_i;
  assign slots[3] = slot3_i;
  assign slots[4] = slot4_i;
  assign slots[5] = slot5_i;
  assign slots[6] = slot6_i;
  assign slots[7] = slot7_i;
  assign slots[8] = slot8_i;

  dmx_slot_sel u_slot_sel (
    .layout_i (layout_q),
    .slot_i   (slots),
    .sel_o    (sel_d)
  );

  logic signed [SampleW-1:0] sel_prev_l_q, sel_prev_r_q;
  logic                      sel_last_q;

  // stage 2: mid sum times gain
  logic signed [GainW:0]     gain_s;
  logic signed [ProdW-1:0]   prod_d, prod_q;
  logic signed [PreW-1:0]    mul_lt_q, mul_rt_q;
  logic signed [SampleW-1:0] mul_prev_l_q, mul_prev_r_q;
  logic                      mul_last_q;

  assign gain_s = {1'b0, gain_q};
  assign prod_d = sel_q.mid * gain_s;

  // stage 3: left and right lanes into the output register
  logic signed [SampleW-1:0] left_d, right_d, left_q, right_q;
  logic                      last_q;

  dmx_lane u_lane_left (
    .pre_i    (mul_lt_q),
    .prod_i   (prod_q),
    .prev_i   (mul_prev_l_q),
    .acc_i    (acc_mode_q),
    .sample_o (left_d)
  );

  dmx_lane u_lane_right (
    .pre_i    (mul_rt_q),
    .prod_i   (prod_q),
    .prev_i   (mul_prev_r_q),
    .acc_i    (acc_mode_q),
    .sample_o (right_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q <= 1'b0;
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sel_en) begin
        sel_valid_q <= in_valid_i;
      end
      if (mul_en) begin
        mul_valid_q <= sel_valid_q;
      end
      if (out_en) begin
        out_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_en && in_valid_i) begin
      sel_q        <= sel_d;
      sel_prev_l_q <= prev_left_i;
      sel_prev_r_q <= prev_right_i;
      sel_last_q   <= last_frame_i;
    end
    if (mul_en && sel_valid_q) begin
      prod_q       <= prod_d;
      mul_lt_q     <= sel_q.lt_pre;
      mul_rt_q     <= sel_q.rt_pre;
      mul_prev_l_q <= sel_prev_l_q;
      mul_prev_r_q <= sel_prev_r_q;
      mul_last_q   <= sel_last_q;
    end
    if (out_en && mul_valid_q) begin
      left_q  <= left_d;
      right_q <= right_d;
      last_q  <= mul_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;
  assign last_out_o  = last_q;

`ifndef SYNTH
  // input stalls only when every stage is full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (sel_valid_q && mul_valid_q && out_valid_o && !out_ready_i))
    else $error("input stalled with room in the pipeline");

  // an output word leaves only when taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("output word dropped without handshake");

  // a word in the multiply stage reaches the output once it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_valid_q && out_en) |=> out_valid_o)
    else $error("word lost between multiply stage and output");
`endif

endmodule
